// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/asr_pkg.sv =====
// ---------------------------------------------------------------------------
// asr_pkg
// Types and constants of the altitude spike rejector.
// ---------------------------------------------------------------------------
`default_nettype none

package asr_pkg;

    localparam int RAW_W   = 21;
    localparam int ALT_W   = 22;
    localparam int DELTA_W = 23;
    localparam int TIME_W  = 32;
    localparam int RATE_W  = 24;
    localparam int LIM_W   = 20;
    localparam int TLIM_W  = 16;
    localparam int CMP_W   = 27;

    typedef logic [2:0] t_state;
    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_reg_idx;

    // register indexes
    localparam t_reg_idx REG_OFFSET     = 2'd0;
    localparam t_reg_idx REG_CLIMB_LIM  = 2'd1;
    localparam t_reg_idx REG_TIME_LIM   = 2'd2;

    // sequencer states
    localparam t_state ST_IDLE = 3'd0;
    localparam t_state ST_PREP = 3'd1;
    localparam t_state ST_MUL  = 3'd2;
    localparam t_state ST_DIV  = 3'd3;
    localparam t_state ST_SAT  = 3'd4;
    localparam t_state ST_CHK  = 3'd5;
    localparam t_state ST_FIN  = 3'd6;

    // how the current item updates the held state
    localparam t_kind KIND_FIRST = 2'd0;
    localparam t_kind KIND_SKIP  = 2'd1;
    localparam t_kind KIND_EVAL  = 2'd2;

    localparam logic signed [RATE_W-1:0] RATE_MAX = 24'sh7FFFFF;
    localparam logic signed [RATE_W-1:0] RATE_MIN = -24'sh800000;
    localparam logic [9:0]               MS_PER_S = 10'd1000;

    localparam logic signed [RAW_W-1:0]  RST_OFFSET    = 21'sd0;
    localparam logic [LIM_W-1:0]         RST_CLIMB_LIM = 20'd1000;
    localparam logic [TLIM_W-1:0]        RST_TIME_LIM  = 16'd1000;

endpackage

`default_nettype wire

// ===== rtl/altitude_spike_rejector_top.sv =====
// ---------------------------------------------------------------------------
// altitude_spike_rejector_top
// Rejects implausible jumps in a stream of barometric altitude samples.
// ---------------------------------------------------------------------------
// Usage:
//  - Input items on s_t*: raw altitude and millisecond timestamp. One result
//    item on m_t* for every input item: held altitude, last rate, and the
//    updated flag on m_tuser.
//  - Configuration through i_cfg_we / i_cfg_idx / i_cfg_data, one register
//    per write, only while the block is idle.
//  - One item at a time: s_tready is high only in the idle state. An examined
//    sample runs a restoring divider, one quotient bit per cycle, and no new
//    sample is taken until its result is loaded into the output register.
//    First samples, unchanged and unexpired samples, and samples with zero
//    elapsed time skip the divider.
//  - The result sits in an output register; if m_tready is low when the next
//    result is ready, the sequencer waits and the held state is not updated
//    until that result can be loaded.
//  - Synchronous active-low reset clears the held state, restores register
//    defaults and empties the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module altitude_spike_rejector_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [20:0] i_cfg_data,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // [20:0] raw_altitude_cm, [52:21] time_ms
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [21:0] altitude_cm, [45:22] climb_rate_cm_s
    output logic             m_tuser    // [0] updated
);

    localparam int ALT_W   = asr_pkg::ALT_W;
    localparam int DELTA_W = asr_pkg::DELTA_W;
    localparam int TIME_W  = asr_pkg::TIME_W;
    localparam int RATE_W  = asr_pkg::RATE_W;
    localparam int LIM_W   = asr_pkg::LIM_W;
    localparam int TLIM_W  = asr_pkg::TLIM_W;
    localparam int RAW_W   = asr_pkg::RAW_W;
    localparam int CMP_W   = asr_pkg::CMP_W;

    // configuration registers
    logic signed [RAW_W-1:0]   r_off;
    logic [LIM_W-1:0]          r_lim;
    logic [TLIM_W-1:0]         r_tlim;

    // held state
    logic                      r_have;
    logic signed [ALT_W-1:0]   r_held_alt;
    logic [TIME_W-1:0]         r_held_time;
    logic signed [RATE_W-1:0]  r_held_rate;
    logic                      r_flag;

    // working registers
    asr_pkg::t_state           r_state;
    asr_pkg::t_kind            r_kind;
    logic signed [ALT_W-1:0]   r_read;
    logic [TIME_W-1:0]         r_now;
    logic signed [DELTA_W-1:0] r_delta;
    logic [TIME_W-1:0]         r_elapsed;
    logic                      r_expired;
    logic [TIME_W-1:0]         r_rem;
    logic [TIME_W-1:0]         r_quo;
    logic [4:0]                r_cnt;
    logic signed [RATE_W-1:0]  r_new_rate;
    logic                      r_take;

    // output register
    logic                      r_m_valid;
    logic signed [ALT_W-1:0]   r_m_alt;
    logic signed [RATE_W-1:0]  r_m_rate;
    logic                      r_m_upd;

    // next held state
    logic                      n_have;
    logic signed [ALT_W-1:0]   n_held_alt;
    logic [TIME_W-1:0]         n_held_time;
    logic signed [RATE_W-1:0]  n_held_rate;
    logic                      n_flag;

    logic                      in_acc;
    logic                      fin_go;
    logic signed [ALT_W-1:0]   reading;
    logic [TIME_W-1:0]         elapsed;
    logic [DELTA_W-1:0]        abs_delta;
    logic [TIME_W:0]           product;
    logic [TIME_W:0]           trial;
    logic [TIME_W:0]           diff;
    logic                      trial_ge;
    logic signed [CMP_W-1:0]   rate_x2;
    logic signed [CMP_W-1:0]   rate_ext;
    logic signed [CMP_W-1:0]   lim_neg5;
    logic signed [CMP_W-1:0]   lim_ext;
    logic                      rate_ok;

    assign s_tready = (r_state == asr_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign fin_go   = (r_state == asr_pkg::ST_FIN) && (!r_m_valid || m_tready);

    assign reading   = ALT_W'($signed(s_tdata[RAW_W-1:0])) - ALT_W'(r_off);
    assign elapsed   = r_now - r_held_time;
    assign abs_delta = r_delta[DELTA_W-1] ? DELTA_W'(-r_delta) : DELTA_W'(r_delta);
    assign product   = (TIME_W+1)'(abs_delta) * (TIME_W+1)'(asr_pkg::MS_PER_S);

    // restoring divider step
    assign trial    = {r_rem, r_quo[TIME_W-1]};
    assign trial_ge = trial >= {1'b0, r_elapsed};
    assign diff     = trial - {1'b0, r_elapsed};

    // window: 2*rate > -5*limit and rate < limit
    assign rate_ext = CMP_W'(r_new_rate);
    assign rate_x2  = rate_ext <<< 1;
    assign lim_ext  = $signed({{(CMP_W-LIM_W){1'b0}}, r_lim});
    assign lim_neg5 = -(lim_ext + (lim_ext <<< 2));
    assign rate_ok  = (rate_x2 > lim_neg5) && (rate_ext < lim_ext);

    always_comb begin
        n_have      = r_have;
        n_held_alt  = r_held_alt;
        n_held_time = r_held_time;
        n_held_rate = r_held_rate;
        n_flag      = r_flag;
        unique case (r_kind)
            asr_pkg::KIND_FIRST: begin
                n_have      = 1'b1;
                n_held_alt  = r_read;
                n_held_time = r_now;
                n_held_rate = '0;
                n_flag      = 1'b1;
            end
            asr_pkg::KIND_EVAL: begin
                n_held_rate = r_new_rate;
                n_flag      = r_take;
                if (r_take) begin
                    n_held_alt  = r_read;
                    n_held_time = r_now;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off       <= asr_pkg::RST_OFFSET;
            r_lim       <= asr_pkg::RST_CLIMB_LIM;
            r_tlim      <= asr_pkg::RST_TIME_LIM;
            r_have      <= 1'b0;
            r_held_alt  <= '0;
            r_held_time <= '0;
            r_held_rate <= '0;
            r_flag      <= 1'b0;
            r_state     <= asr_pkg::ST_IDLE;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    asr_pkg::REG_OFFSET:    r_off  <= $signed(i_cfg_data);
                    asr_pkg::REG_CLIMB_LIM: r_lim  <= i_cfg_data[LIM_W-1:0];
                    asr_pkg::REG_TIME_LIM:  r_tlim <= i_cfg_data[TLIM_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (fin_go) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                asr_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= asr_pkg::ST_PREP;
                    end
                end
                asr_pkg::ST_PREP: begin
                    r_state <= asr_pkg::ST_MUL;
                end
                asr_pkg::ST_MUL: begin
                    if (!r_have || (r_delta == '0 && !r_expired)) begin
                        r_state <= asr_pkg::ST_FIN;
                    end else if (r_elapsed == '0) begin
                        r_state <= asr_pkg::ST_CHK;
                    end else begin
                        r_state <= asr_pkg::ST_DIV;
                    end
                end
                asr_pkg::ST_DIV: begin
                    if (r_cnt == 5'd31) begin
                        r_state <= asr_pkg::ST_SAT;
                    end
                end
                asr_pkg::ST_SAT: begin
                    r_state <= asr_pkg::ST_CHK;
                end
                asr_pkg::ST_CHK: begin
                    r_state <= asr_pkg::ST_FIN;
                end
                asr_pkg::ST_FIN: begin
                    if (fin_go) begin
                        r_have      <= n_have;
                        r_held_alt  <= n_held_alt;
                        r_held_time <= n_held_time;
                        r_held_rate <= n_held_rate;
                        r_flag      <= n_flag;
                        r_state     <= asr_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= asr_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            asr_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_read <= reading;
                    r_now  <= s_tdata[RAW_W+TIME_W-1:RAW_W];
                end
            end
            asr_pkg::ST_PREP: begin
                r_delta   <= DELTA_W'(r_read) - DELTA_W'(r_held_alt);
                r_elapsed <= elapsed;
                r_expired <= elapsed > TIME_W'(r_tlim);
            end
            asr_pkg::ST_MUL: begin
                if (!r_have) begin
                    r_kind <= asr_pkg::KIND_FIRST;
                end else if (r_delta == '0 && !r_expired) begin
                    r_kind <= asr_pkg::KIND_SKIP;
                end else begin
                    r_kind <= asr_pkg::KIND_EVAL;
                end
                // zero elapsed: saturate by sign
                if (r_delta[DELTA_W-1]) begin
                    r_new_rate <= asr_pkg::RATE_MIN;
                end else if (r_delta != '0) begin
                    r_new_rate <= asr_pkg::RATE_MAX;
                end else begin
                    r_new_rate <= '0;
                end
                r_quo <= product[TIME_W-1:0];
                r_rem <= '0;
                r_cnt <= '0;
            end
            asr_pkg::ST_DIV: begin
                r_rem <= trial_ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
                r_quo <= {r_quo[TIME_W-2:0], trial_ge};
                r_cnt <= r_cnt + 5'd1;
            end
            asr_pkg::ST_SAT: begin
                if (r_delta[DELTA_W-1]) begin
                    if (r_quo > TIME_W'(24'h800000)) begin
                        r_new_rate <= asr_pkg::RATE_MIN;
                    end else begin
                        r_new_rate <= -$signed(r_quo[RATE_W-1:0]);
                    end
                end else begin
                    if (r_quo > TIME_W'(24'h7FFFFF)) begin
                        r_new_rate <= asr_pkg::RATE_MAX;
                    end else begin
                        r_new_rate <= $signed(r_quo[RATE_W-1:0]);
                    end
                end
            end
            asr_pkg::ST_CHK: begin
                r_take <= rate_ok || r_expired;
            end
            asr_pkg::ST_FIN: begin
                if (fin_go) begin
                    r_m_alt  <= n_held_alt;
                    r_m_rate <= n_held_rate;
                    r_m_upd  <= n_flag;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {2'b00, r_m_rate, r_m_alt};
    assign m_tuser  = r_m_upd;

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_div_rem_below_den, i_clk, i_rst_n,
        (r_state != asr_pkg::ST_DIV) || (r_rem < r_elapsed))
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !s_tready)
    `ASSERT_ALWAYS(a_rate_zero_before_first, i_clk, i_rst_n,
        r_have || (r_held_rate == '0 && !r_flag))
    `ASSERT_NEXT(a_fin_loads_output, i_clk, i_rst_n, fin_go, m_tvalid)

endmodule

`default_nettype wire

// ===== verif/tb_altitude_spike_rejector_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_altitude_spike_rejector_top
// Self-checking bench for the altitude spike rejector. Altitude/timestamp
// items are streamed in with random source gaps and sink stalls. A
// cycle-free software filter predicts the held altitude, rate and updated
// flag of every item, and each result is compared field by field in order.
// Directed items cover the first sample, the rate window edges, zero elapsed
// time, expiry and timestamp wrap. Register extremes follow, then random
// flight profiles under several register settings.
// ---------------------------------------------------------------------------
module tb_altitude_spike_rejector_top;

    typedef struct packed {
        logic signed [asr_pkg::ALT_W-1:0]  alt;
        logic signed [asr_pkg::RATE_W-1:0] rate;
        logic                              upd;
    } t_filt_res;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = asr_pkg::REG_OFFSET;
    logic [20:0] i_cfg_data = '0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata    = '0;   // [20:0] raw_altitude_cm, [52:21] time_ms
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [47:0] m_tdata;           // [21:0] altitude_cm, [45:22] climb_rate_cm_s
    logic        m_tuser;           // [0] updated

    altitude_spike_rejector_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // filter copy: registers and held state
    logic signed [asr_pkg::RAW_W-1:0]  cal_offset = asr_pkg::RST_OFFSET;
    logic [asr_pkg::LIM_W-1:0]         climb_lim  = asr_pkg::RST_CLIMB_LIM;
    logic [asr_pkg::TLIM_W-1:0]        time_lim   = asr_pkg::RST_TIME_LIM;
    logic                              have_alt   = 1'b0;
    logic signed [asr_pkg::ALT_W-1:0]  held_alt   = '0;
    logic [asr_pkg::TIME_W-1:0]        held_time  = '0;
    logic signed [asr_pkg::RATE_W-1:0] held_rate  = '0;
    logic                              held_upd   = 1'b0;

    t_filt_res filtered_q[$];
    int        errors     = 0;
    int        n_items    = 0;
    int        n_updated  = 0;
    int        n_rejected = 0;
    int        n_settings = 1;
    bit        steady     = 1'b0;
    int        stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_filt_res filter_reading(
            logic signed [asr_pkg::RAW_W-1:0] raw,
            logic [asr_pkg::TIME_W-1:0] tm);
        longint     reading;
        longint     delta;
        longint     r;
        longint     lim;
        logic [31:0] elapsed;
        logic       expired;
        logic       ok;
        reading = longint'(raw) - longint'(cal_offset);
        if (!have_alt) begin
            have_alt  = 1'b1;
            held_alt  = reading[asr_pkg::ALT_W-1:0];
            held_time = tm;
            held_rate = '0;
            held_upd  = 1'b1;
        end else begin
            elapsed = tm - held_time;
            expired = elapsed > {16'd0, time_lim};
            delta   = reading - longint'(held_alt);
            if (delta != 0 || expired) begin
                if (elapsed == 0) begin
                    if (delta > 0)
                        r = longint'(asr_pkg::RATE_MAX);
                    else if (delta < 0)
                        r = longint'(asr_pkg::RATE_MIN);
                    else
                        r = 0;
                end else begin
                    r = (delta * longint'(asr_pkg::MS_PER_S)) / longint'(elapsed);
                    if (r > longint'(asr_pkg::RATE_MAX))
                        r = longint'(asr_pkg::RATE_MAX);
                    if (r < longint'(asr_pkg::RATE_MIN))
                        r = longint'(asr_pkg::RATE_MIN);
                end
                lim       = longint'(climb_lim);
                ok        = (2 * r > -5 * lim) && (r < lim);
                held_rate = r[asr_pkg::RATE_W-1:0];
                if (ok || expired) begin
                    held_alt  = reading[asr_pkg::ALT_W-1:0];
                    held_time = tm;
                    held_upd  = 1'b1;
                end else begin
                    held_upd  = 1'b0;
                end
            end
        end
        return '{held_alt, held_rate, held_upd};
    endfunction

    task automatic send_reading(input logic signed [asr_pkg::RAW_W-1:0] raw,
                                input logic [asr_pkg::TIME_W-1:0] tm);
        int        gap;
        t_filt_res res;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(0, 99) < 38)
                gap++;
            if ($urandom_range(0, 15) == 0)
                gap += $urandom_range(1, 80);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, tm, raw};
        do
            @(posedge i_clk);
        while (!s_tready);
        res = filter_reading(raw, tm);
        filtered_q.push_back(res);
        n_items++;
        if (res.upd)
            n_updated++;
        else
            n_rejected++;
    endtask

    // lowers valid in the step of the last handshake, then waits for results
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (filtered_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_set(input logic signed [asr_pkg::RAW_W-1:0] off,
                           input logic [asr_pkg::LIM_W-1:0] climb,
                           input logic [asr_pkg::TLIM_W-1:0] tl);
        wait_drained();
        repeat (5) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= asr_pkg::REG_OFFSET;
        i_cfg_data <= off;
        @(posedge i_clk);
        cal_offset = off;
        i_cfg_idx  <= asr_pkg::REG_CLIMB_LIM;
        i_cfg_data <= 21'(climb);
        @(posedge i_clk);
        climb_lim  = climb;
        i_cfg_idx  <= asr_pkg::REG_TIME_LIM;
        i_cfg_data <= 21'(tl);
        @(posedge i_clk);
        time_lim   = tl;
        i_cfg_we   <= 1'b0;
        n_settings++;
    endtask

    // reset register values: window edges, zero elapsed, expiry, wrap
    task automatic test_rate_window();
        send_reading(0, 0);
        send_reading(0, 500);
        send_reading(500, 1000);
        send_reading(5000, 1100);
        send_reading(-1900, 2000);
        send_reading(-4400, 3000);
        send_reading(-900, 3000);
        send_reading(-1899, 2000);
        send_reading(-1901, 2000);
        send_reading(-1900, 2500);
        send_reading(1000000, 3001);
        send_reading(1000000, 4002);
        send_reading(-1048576, 32'hFFFF_FF00);
        send_reading(-1048570, 32'h0000_0010);
    endtask

    // offset extremes, zero climb limit, smallest and largest time limit
    task automatic test_register_extremes();
        cfg_set(-21'sd1048576, '0, 16'd1);
        send_reading(21'sd1048575, 32'h10);
        send_reading(21'sd1048575, 32'h11);
        send_reading(21'sd1048575, 32'h12);
        send_reading(-21'sd1048576, 32'h13);
        cfg_set(21'sd1048575, 20'hFFFFF, 16'hFFFF);
        send_reading(-21'sd1048576, 32'h10011);
        send_reading(-21'sd1048576, 32'h10011 + 32'd65535);
        send_reading(-21'sd1048576, 32'h10011 + 32'd65536);
        send_reading(21'sd1048575, 32'h10011 + 32'd65537);
    endtask

    // plausible flight profile with duplicates, spikes and time jumps
    task automatic test_random_flight(input int n_readings, input bit no_gaps);
        longint                           step;
        longint                           rt;
        longint                           lim;
        longint                           nraw;
        logic signed [asr_pkg::RAW_W-1:0] raw;
        logic [asr_pkg::TIME_W-1:0]       tm;
        int                               sel;
        steady = no_gaps;
        raw = 21'($urandom);
        tm  = $urandom;
        lim = longint'(climb_lim);
        for (int i = 0; i < n_readings; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                step = $urandom_range(1, 200);
            end else if (sel < 78) begin
                step = 0;
            end else if (sel < 90) begin
                step = longint'(time_lim) + longint'($urandom_range(0, 4)) - 2;
                if (step < 0)
                    step = 0;
            end else begin
                step = $urandom;
            end
            tm  = tm + step[31:0];
            sel = $urandom_range(0, 99);
            if (sel >= 22) begin
                rt   = longint'($urandom_range(0, 4500)) * lim / 1000 - 3 * lim;
                nraw = longint'(raw) + rt * step / 1000;
                if (nraw > 1048575)
                    nraw = 1048575;
                if (nraw < -1048576)
                    nraw = -1048576;
                raw = nraw[asr_pkg::RAW_W-1:0];
            end else if (sel >= 12) begin
                raw = 21'($urandom);
            end
            send_reading(raw, tm);
        end
    endtask

    always @(posedge i_clk) begin
        t_filt_res want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (filtered_q.size() == 0) begin
                $error("result item with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want = filtered_q.pop_front();
                if (m_tdata[21:0] !== want.alt) begin
                    $error("altitude_cm: expected %0d, got %0d",
                           $signed(want.alt), $signed(m_tdata[21:0]));
                    errors++;
                end
                if (m_tdata[45:22] !== want.rate) begin
                    $error("climb_rate_cm_s: expected %0d, got %0d",
                           $signed(want.rate), $signed(m_tdata[45:22]));
                    errors++;
                end
                if (m_tuser !== want.upd) begin
                    $error("updated: expected %0b, got %0b", want.upd, m_tuser);
                    errors++;
                end
            end
        end
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 199) == 0) begin
            stall_left = $urandom_range(1, 60);
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 38);
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_rate_window();
        test_register_extremes();
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: cfg_set(21'($urandom), asr_pkg::RST_CLIMB_LIM, asr_pkg::RST_TIME_LIM);
                1: cfg_set(21'($urandom), 20'hFFFFF, 16'hFFFF);
                2: cfg_set(21'($urandom), 20'd1, 16'd1);
                default: begin
                    cfg_set(21'($urandom),
                            20'($urandom_range(0, 1) ? $urandom_range(1, 5000)
                                                     : $urandom_range(0, 20'hFFFFF)),
                            16'($urandom_range(0, 1) ? $urandom_range(1, 2000)
                                                     : $urandom_range(1, 65535)));
                end
            endcase
            test_random_flight(160, p == 0);
        end
        wait_drained();
        repeat (60) @(posedge i_clk);
        $display("Covered %0d items over %0d register settings: %0d updated, %0d rejected",
                 n_items, n_settings, n_updated, n_rejected);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
